// File: sv/dnp_pkg.sv
// ----------------------------------------------------------------------------
// dnp_pkg: shared types and constants of the distinguished-name parser
// Character classes, result records, parser phases and attribute codes.
// ----------------------------------------------------------------------------
package dnp_pkg;

  localparam int unsigned MAX_KEY_CHARS = 6;
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // Depths of the classified-character queue and the result queue.
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned RQ_DEPTH = 4;

  // Attribute codes (last arc of the attribute OID).
  localparam logic [3:0] ATTR_NONE   = 4'd0;
  localparam logic [3:0] ATTR_CN     = 4'd3;
  localparam logic [3:0] ATTR_C      = 4'd6;
  localparam logic [3:0] ATTR_L      = 4'd7;
  localparam logic [3:0] ATTR_ST     = 4'd8;
  localparam logic [3:0] ATTR_STREET = 4'd9;
  localparam logic [3:0] ATTR_O      = 4'd10;
  localparam logic [3:0] ATTR_OU     = 4'd11;

  // Key spellings, right aligned as the key register collects them.
  localparam logic [7:0]  KEY_L      = 8'h4C;
  localparam logic [7:0]  KEY_O      = 8'h4F;
  localparam logic [7:0]  KEY_C      = 8'h43;
  localparam logic [15:0] KEY_CN     = 16'h434E;
  localparam logic [15:0] KEY_ST     = 16'h5354;
  localparam logic [15:0] KEY_OU     = 16'h4F55;
  localparam logic [47:0] KEY_STREET = 48'h535452454554;
  localparam logic [7:0]  KEY_GAP_CHAR = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_ERROR  = 2'd3
  } dnp_kind_e;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_KEY_WORD = 3'd1,
    PH_KEY_GAP  = 3'd2,
    PH_PRE_EQ   = 3'd3,
    PH_POST_EQ  = 3'd4,
    PH_VALUE    = 3'd5,
    PH_SEP_PRE  = 3'd6,
    PH_SEP_POST = 3'd7
  } dnp_phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] char_in;
  } dnp_in_t;

  typedef struct packed {
    dnp_kind_e   kind;
    logic [3:0]  attr_code;
    logic [7:0]  data_byte;
    logic [15:0] value_length;
  } dnp_out_t;

  // One character after classification.
  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
    logic       alnum;
    logic       plain;
    logic       space;
    logic       newline;
    logic       eq;
    logic       quote;
    logic       bslash;
    logic       hash;
    logic       sep;
  } dnp_cls_t;

  // Results of one character, written to the result queue together.
  typedef struct packed {
    logic [1:0] cnt;
    dnp_out_t   r0;
    dnp_out_t   r1;
  } dnp_wr_t;

  function automatic dnp_out_t mk_res(dnp_kind_e k, logic [3:0] a, logic [7:0] d,
                                      logic [15:0] l);
    dnp_out_t r;
    r.kind         = k;
    r.attr_code    = a;
    r.data_byte    = d;
    r.value_length = l;
    return r;
  endfunction

endpackage

// File: sv/dn_string_parser.sv
// ----------------------------------------------------------------------------
// dn_string_parser: distinguished-name string parser, top level
// A character is registered in the intake queue, then parsed, and its results are
// registered in the result queue; a parser step waits for room in that queue.
// Throughput: one character per cycle while results drain one per cycle; a
// character with two results uses two slots of the four-entry result queue.
// The parser steps only when that queue has two free slots.
// Reset clears all parse state and sets buffer_capacity to 65535.
// ----------------------------------------------------------------------------
module dn_string_parser #(
  parameter int unsigned MaxKeyChars = dnp_pkg::MAX_KEY_CHARS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  dnp_pkg::dnp_in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output dnp_pkg::dnp_out_t out_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import dnp_pkg::*;

  logic     item_valid, item_pop, room;
  dnp_cls_t item;
  dnp_wr_t  wr;

  dnp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .in_i    (in_i),
    .full_o  (full),
    .pop_i   (item_pop),
    .valid_o (item_valid),
    .item_o  (item)
  );

  dnp_back #(
    .MaxKeyChars (MaxKeyChars)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (item_valid),
    .item_i      (item),
    .room_i      (room),
    .pop_o       (item_pop),
    .wr_o        (wr)
  );

  dnp_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .room_o  (room),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (out_o)
  );

  // The parser only consumes characters that the intake queue holds.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("parser consumed from an empty character queue");

  // Results are only written when the result queue has room for two.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.cnt != 2'd0) |-> room)
    else $error("result written without queue room");

  // Accept and error results carry no attribute, byte or length.
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.kind == KIND_ACCEPT || out_o.kind == KIND_ERROR)) |->
      (out_o.attr_code == ATTR_NONE && out_o.data_byte == 8'd0 &&
       out_o.value_length == 16'd0))
    else $error("status result carries stale payload");

endmodule

// File: sv/dnp_front.sv
// ----------------------------------------------------------------------------
// dnp_front: character intake
// Classifies each accepted character and holds it in a short queue until the
// parser takes it.
// ----------------------------------------------------------------------------
module dnp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dnp_pkg::dnp_in_t in_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dnp_pkg::dnp_cls_t item_o
);
  import dnp_pkg::*;

  localparam int unsigned PtrW = $clog2(FQ_DEPTH);
  localparam int unsigned CntW = $clog2(FQ_DEPTH + 1);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChBslash = 8'h5C;

  dnp_cls_t        mem_q [FQ_DEPTH];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  dnp_cls_t        cls;
  logic [7:0]      lower;
  logic            push_ok;

  always_comb begin
    lower       = in_i.char_in | 8'h20;
    cls.ch      = in_i.char_in;
    cls.is_end  = in_i.func || (in_i.char_in == ChNul);
    cls.alnum   = (in_i.char_in >= 8'h30 && in_i.char_in <= 8'h39) ||
                  (lower >= 8'h61 && lower <= 8'h7A);
    cls.space   = in_i.char_in == ChSpace;
    cls.newline = in_i.char_in == ChNl;
    cls.eq      = in_i.char_in == ChEq;
    cls.quote   = in_i.char_in == ChQuote;
    cls.bslash  = in_i.char_in == ChBslash;
    cls.hash    = in_i.char_in == ChHash;
    cls.sep     = (in_i.char_in == ChComma) || (in_i.char_in == ChSemi);
    cls.plain   = !(cls.sep || cls.eq || cls.newline || cls.hash || cls.quote ||
                    cls.bslash || in_i.char_in == ChPlus || in_i.char_in == ChLt ||
                    in_i.char_in == ChGt || in_i.char_in == ChNul);
  end

  assign full_o  = cnt_q == CntW'(FQ_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign push_ok = push_i && !full_o;

  always_comb begin
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    wr_d  = push_ok ? wr_q + PtrW'(1) : wr_q;
    cnt_d = cnt_q + CntW'(push_ok) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

// File: sv/dnp_back.sv
// ----------------------------------------------------------------------------
// dnp_back: component parser
// Runs the key / value / separator state machine on one classified character
// per step and produces up to two results for it.
// ----------------------------------------------------------------------------
module dnp_back #(
  parameter int unsigned MaxKeyChars = dnp_pkg::MAX_KEY_CHARS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              valid_i,
  input  dnp_pkg::dnp_cls_t item_i,
  input  logic              room_i,
  output logic              pop_o,
  output dnp_pkg::dnp_wr_t  wr_o
);
  import dnp_pkg::*;

  localparam int unsigned KeyW = 8 * MaxKeyChars;
  localparam int unsigned CntW = $clog2(MaxKeyChars + 2);

  dnp_phase_e      phase_q, phase_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [CntW-1:0] kcnt_q, kcnt_d;
  logic [3:0]      attr_q, attr_d;
  logic            inq_q, inq_d, esc_q, esc_d, nl_q, nl_d, err_q, err_d;
  logic [15:0]     bytes_q, bytes_d, vcnt_q, vcnt_d, cap_q;

  logic                 step, fresh, do_value, do_first, skip, iq, es;
  logic [15:0]          vc;
  logic [3:0]           lookup;
  logic [KeyW+CntW-1:0] k1, k2;

  // Appends one character to the key; an overlong key saturates its count.
  function automatic logic [KeyW+CntW-1:0] key_add(logic [KeyW-1:0] k,
                                                   logic [CntW-1:0] n,
                                                   logic [7:0] c);
    logic [KeyW+CntW-1:0] r;
    if (n < CntW'(MaxKeyChars)) begin
      r = {n + CntW'(1), k[KeyW-9:0], c};
    end else begin
      r = {CntW'(MaxKeyChars + 1), k};
    end
    return r;
  endfunction

  assign step  = valid_i && room_i;
  assign pop_o = step;
  // The optional newline is taken once; a space is always skipped.
  assign skip  = (item_i.newline && !nl_q) || item_i.space;

  always_comb begin
    lookup = ATTR_NONE;
    if (kcnt_q == CntW'(1)) begin
      if (key_q == KeyW'(KEY_L)) lookup = ATTR_L;
      if (key_q == KeyW'(KEY_O)) lookup = ATTR_O;
      if (key_q == KeyW'(KEY_C)) lookup = ATTR_C;
    end else if (kcnt_q == CntW'(2)) begin
      if (key_q == KeyW'(KEY_CN)) lookup = ATTR_CN;
      if (key_q == KeyW'(KEY_ST)) lookup = ATTR_ST;
      if (key_q == KeyW'(KEY_OU)) lookup = ATTR_OU;
    end else if (kcnt_q == CntW'(6)) begin
      if (key_q == KeyW'(KEY_STREET)) lookup = ATTR_STREET;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    key_d    = key_q;
    kcnt_d   = kcnt_q;
    attr_d   = attr_q;
    inq_d    = inq_q;
    esc_d    = esc_q;
    nl_d     = nl_q;
    bytes_d  = bytes_q;
    vcnt_d   = vcnt_q;
    err_d    = err_q;
    fresh    = 1'b0;
    do_value = 1'b0;
    do_first = 1'b0;
    iq       = inq_q;
    es       = esc_q;
    vc       = vcnt_q;
    wr_o     = '0;
    k1       = {kcnt_q, key_q};
    if (phase_q == PH_KEY_GAP) begin
      k1 = key_add(key_q, kcnt_q, KEY_GAP_CHAR);
    end
    k2 = key_add(k1[KeyW-1:0], k1[KeyW+CntW-1:KeyW], item_i.ch);

    if (step) begin
      if (err_q) begin
        // Characters after an error are dropped until the string ends.
        fresh = item_i.is_end;
      end else begin
        unique case (phase_q) inside
          PH_FIRST: begin
            do_first = 1'b1;
          end
          PH_KEY_WORD, PH_KEY_GAP: begin
            if (!item_i.is_end && item_i.alnum) begin
              {kcnt_d, key_d} = k2;
              phase_d = PH_KEY_WORD;
            end else if (!item_i.is_end && item_i.space) begin
              phase_d = PH_KEY_GAP;
            end else if (lookup == ATTR_NONE) begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
              fresh    = item_i.is_end;
              err_d    = !item_i.is_end;
            end else begin
              // Key done; the same character is looked at as the '=' step.
              attr_d = lookup;
              if (!item_i.is_end && item_i.newline) begin
                phase_d = PH_PRE_EQ;
                nl_d    = 1'b1;
              end else if (!item_i.is_end && item_i.eq) begin
                phase_d = PH_POST_EQ;
                nl_d    = 1'b0;
              end else begin
                wr_o.cnt = 2'd1;
                wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
                fresh    = item_i.is_end;
                err_d    = !item_i.is_end;
              end
            end
          end
          PH_PRE_EQ: begin
            if (!item_i.is_end && skip) begin
              nl_d = 1'b1;
            end else if (!item_i.is_end && item_i.eq) begin
              phase_d = PH_POST_EQ;
              nl_d    = 1'b0;
            end else begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
              fresh    = item_i.is_end;
              err_d    = !item_i.is_end;
            end
          end
          PH_POST_EQ: begin
            vcnt_d = '0;
            esc_d  = 1'b0;
            inq_d  = 1'b0;
            if (!item_i.is_end && skip) begin
              nl_d = 1'b1;
            end else if (!item_i.is_end && item_i.hash) begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
              err_d    = 1'b1;
            end else if (!item_i.is_end && item_i.quote) begin
              inq_d   = 1'b1;
              phase_d = PH_VALUE;
            end else begin
              phase_d  = PH_VALUE;
              do_value = 1'b1;
              iq       = 1'b0;
              es       = 1'b0;
              vc       = '0;
            end
          end
          PH_VALUE: begin
            do_value = 1'b1;
          end
          PH_SEP_PRE: begin
            if (item_i.is_end) begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ACCEPT, ATTR_NONE, '0, '0);
              fresh    = 1'b1;
            end else if (skip) begin
              nl_d = 1'b1;
            end else if (item_i.sep) begin
              phase_d = PH_SEP_POST;
              nl_d    = 1'b0;
            end else begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
              err_d    = 1'b1;
            end
          end
          PH_SEP_POST: begin
            if (item_i.is_end) begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ACCEPT, ATTR_NONE, '0, '0);
              fresh    = 1'b1;
            end else if (skip) begin
              nl_d = 1'b1;
            end else begin
              do_first = 1'b1;
            end
          end
        endcase

        if (do_first) begin
          if (!item_i.is_end && item_i.alnum) begin
            key_d   = KeyW'(item_i.ch);
            kcnt_d  = CntW'(1);
            phase_d = PH_KEY_WORD;
          end else begin
            wr_o.cnt = 2'd1;
            wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
            fresh    = item_i.is_end;
            err_d    = !item_i.is_end;
          end
        end

        if (do_value) begin
          if (item_i.is_end) begin
            if (iq || es) begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
            end else begin
              wr_o.cnt = 2'd2;
              wr_o.r0  = mk_res(KIND_END, attr_q, '0, vc);
              wr_o.r1  = mk_res(KIND_ACCEPT, ATTR_NONE, '0, '0);
            end
            fresh = 1'b1;
          end else if (es || (iq && !item_i.quote && !item_i.bslash) ||
                       (!iq && item_i.plain)) begin
            // Value byte, subject to the total buffer limit.
            esc_d = 1'b0;
            if (bytes_q >= cap_q) begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
              err_d    = 1'b1;
            end else begin
              wr_o.cnt = 2'd1;
              wr_o.r0  = mk_res(KIND_BYTE, attr_q, item_i.ch, '0);
              bytes_d  = bytes_q + 16'd1;
              vcnt_d   = vc + 16'd1;
            end
          end else if (item_i.bslash) begin
            esc_d = 1'b1;
          end else if (iq) begin
            // Closing quote ends the value.
            wr_o.cnt = 2'd1;
            wr_o.r0  = mk_res(KIND_END, attr_q, '0, vc);
            phase_d  = PH_SEP_PRE;
            nl_d     = 1'b0;
          end else begin
            // A special character ends an unquoted value and is then parsed
            // as the first character after it.
            wr_o.cnt = 2'd1;
            wr_o.r0  = mk_res(KIND_END, attr_q, '0, vc);
            if (item_i.newline || item_i.space) begin
              phase_d = PH_SEP_PRE;
              nl_d    = 1'b1;
            end else if (item_i.sep) begin
              phase_d = PH_SEP_POST;
              nl_d    = 1'b0;
            end else begin
              wr_o.cnt = 2'd2;
              wr_o.r1  = mk_res(KIND_ERROR, ATTR_NONE, '0, '0);
              err_d    = 1'b1;
            end
          end
        end
      end

      if (fresh) begin
        phase_d = PH_FIRST;
        key_d   = '0;
        kcnt_d  = '0;
        attr_d  = ATTR_NONE;
        inq_d   = 1'b0;
        esc_d   = 1'b0;
        nl_d    = 1'b0;
        bytes_d = '0;
        vcnt_d  = '0;
        err_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      key_q   <= '0;
      kcnt_q  <= '0;
      attr_q  <= ATTR_NONE;
      inq_q   <= 1'b0;
      esc_q   <= 1'b0;
      nl_q    <= 1'b0;
      bytes_q <= '0;
      vcnt_q  <= '0;
      err_q   <= 1'b0;
      cap_q   <= CAPACITY_RESET;
    end else begin
      phase_q <= phase_d;
      key_q   <= key_d;
      kcnt_q  <= kcnt_d;
      attr_q  <= attr_d;
      inq_q   <= inq_d;
      esc_q   <= esc_d;
      nl_q    <= nl_d;
      bytes_q <= bytes_d;
      vcnt_q  <= vcnt_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: sv/dnp_rfifo.sv
// ----------------------------------------------------------------------------
// dnp_rfifo: result queue
// Takes up to two results per cycle from the parser and hands out one per
// transaction, oldest first.
// ----------------------------------------------------------------------------
module dnp_rfifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dnp_pkg::dnp_wr_t  wr_i,
  output logic              room_o,
  input  logic              pop_i,
  output logic              empty_o,
  output dnp_pkg::dnp_out_t head_o
);
  import dnp_pkg::*;

  localparam int unsigned PtrW = $clog2(RQ_DEPTH);
  localparam int unsigned CntW = $clog2(RQ_DEPTH + 1);

  dnp_out_t        mem_q [RQ_DEPTH];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop_ok;

  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= CntW'(RQ_DEPTH - 2);
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    rd_d  = pop_ok ? rd_q + PtrW'(1) : rd_q;
    wr_d  = wr_q + PtrW'(wr_i.cnt);
    cnt_d = cnt_q + CntW'(wr_i.cnt) - CntW'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wr_q] <= wr_i.r0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= wr_i.r1;
    end
  end

endmodule

// File: tb/sv/dn_parse_check.sv
// ----------------------------------------------------------------------------
// dn_parse_check: result predictor and comparator for dn_string_parser
// Watches the character, result and configuration channels. Every accepted
// character is run through a cycle-free model of the parser, and the records
// it produces are queued. Every accepted result is compared field by field
// with the oldest queued record.
// ----------------------------------------------------------------------------
module dn_parse_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  dnp_pkg::dnp_in_t  item_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  dnp_pkg::dnp_out_t res_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output int unsigned       fail_count_o,
  output int unsigned       due_count_o
);
  import dnp_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  dnp_out_t    dn_results_due[$];
  dnp_phase_e  ph;
  logic [47:0] key_reg;
  logic [2:0]  key_len;
  logic [3:0]  cur_attr;
  logic        quoted;
  logic        escaped;
  logic        nl_used;
  logic        err_seen;
  logic [15:0] bytes_used;
  logic [15:0] val_len;
  logic [15:0] capacity;
  int unsigned fails;
  dnp_out_t    want;

  function automatic logic is_alnum(input logic [7:0] ch);
    logic [7:0] folded;
    folded = ch | 8'h20;
    return (ch >= "0" && ch <= "9") || (folded >= "a" && folded <= "z");
  endfunction

  // One newline may be skipped, but only before the first space.
  function automatic logic take_space(input logic [7:0] ch);
    if ((ch == CH_NL && !nl_used) || ch == CH_SPACE) begin
      nl_used = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic start_string();
    ph         = PH_FIRST;
    key_reg    = '0;
    key_len    = '0;
    cur_attr   = ATTR_NONE;
    quoted     = 1'b0;
    escaped    = 1'b0;
    nl_used    = 1'b0;
    bytes_used = '0;
    val_len    = '0;
    err_seen   = 1'b0;
  endtask

  task automatic note(input dnp_kind_e k, input logic [3:0] a, input logic [7:0] d,
                      input logic [15:0] l);
    dnp_out_t rec;
    rec.kind         = k;
    rec.attr_code    = a;
    rec.data_byte    = d;
    rec.value_length = l;
    dn_results_due.push_back(rec);
  endtask

  task automatic add_key_char(input logic [7:0] ch);
    if (key_len < MAX_KEY_CHARS) begin
      key_reg = {key_reg[39:0], ch};
      key_len = key_len + 3'd1;
    end else begin
      key_len = 3'(MAX_KEY_CHARS + 1);
    end
  endtask

  task automatic raise_error(input logic at_end);
    note(KIND_ERROR, ATTR_NONE, 8'h00, 16'h0000);
    if (at_end) start_string();
    else err_seen = 1'b1;
  endtask

  task automatic finish_string();
    note(KIND_ACCEPT, ATTR_NONE, 8'h00, 16'h0000);
    start_string();
  endtask

  task automatic store_byte(input logic [7:0] ch);
    if (bytes_used >= capacity) begin
      raise_error(1'b0);
    end else begin
      note(KIND_BYTE, cur_attr, ch, 16'h0000);
      bytes_used = bytes_used + 16'd1;
      val_len    = val_len + 16'd1;
    end
  endtask

  task automatic close_value();
    note(KIND_END, cur_attr, 8'h00, val_len);
    ph      = PH_SEP_PRE;
    nl_used = 1'b0;
  endtask

  task automatic parse_char(input dnp_in_t item);
    logic [7:0] c;
    logic       term;
    logic       again;
    c    = item.char_in;
    term = item.func || (c == CH_NUL);
    if (err_seen) begin
      // Everything up to the end of the string is dropped silently.
      if (term) start_string();
      return;
    end
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (ph)
        PH_FIRST: begin
          if (!term && is_alnum(c)) begin
            key_reg = '0;
            key_len = '0;
            add_key_char(c);
            ph = PH_KEY_WORD;
          end else begin
            raise_error(term);
          end
        end
        PH_KEY_WORD, PH_KEY_GAP: begin
          if (!term && is_alnum(c)) begin
            if (ph == PH_KEY_GAP) add_key_char(KEY_GAP_CHAR);
            add_key_char(c);
            ph = PH_KEY_WORD;
          end else if (!term && c == CH_SPACE) begin
            ph = PH_KEY_GAP;
          end else begin
            cur_attr = ATTR_NONE;
            if (key_len == 3'd1) begin
              if (key_reg == KEY_L) cur_attr = ATTR_L;
              else if (key_reg == KEY_O) cur_attr = ATTR_O;
              else if (key_reg == KEY_C) cur_attr = ATTR_C;
            end else if (key_len == 3'd2) begin
              if (key_reg == KEY_CN) cur_attr = ATTR_CN;
              else if (key_reg == KEY_ST) cur_attr = ATTR_ST;
              else if (key_reg == KEY_OU) cur_attr = ATTR_OU;
            end else if (key_len == 3'd6 && key_reg == KEY_STREET) begin
              cur_attr = ATTR_STREET;
            end
            if (cur_attr == ATTR_NONE) begin
              raise_error(term);
            end else begin
              ph      = PH_PRE_EQ;
              nl_used = 1'b0;
              again   = 1'b1;
            end
          end
        end
        PH_PRE_EQ: begin
          if (!term && take_space(c)) begin
          end else if (!term && c == CH_EQ) begin
            ph      = PH_POST_EQ;
            nl_used = 1'b0;
          end else begin
            raise_error(term);
          end
        end
        PH_POST_EQ: begin
          val_len = '0;
          escaped = 1'b0;
          quoted  = 1'b0;
          if (!term && take_space(c)) begin
          end else if (!term && c == CH_HASH) begin
            raise_error(1'b0);
          end else if (!term && c == CH_QUOTE) begin
            quoted = 1'b1;
            ph     = PH_VALUE;
          end else begin
            ph    = PH_VALUE;
            again = 1'b1;
          end
        end
        PH_VALUE: begin
          if (term) begin
            if (quoted || escaped) begin
              raise_error(1'b1);
            end else begin
              note(KIND_END, cur_attr, 8'h00, val_len);
              finish_string();
            end
          end else if (escaped) begin
            escaped = 1'b0;
            store_byte(c);
          end else if (c == CH_BSLASH) begin
            escaped = 1'b1;
          end else if (quoted) begin
            if (c == CH_QUOTE) close_value();
            else store_byte(c);
          end else begin
            case (c)
              CH_COMMA, CH_EQ, CH_NL, CH_PLUS, CH_LT, CH_GT, CH_HASH, CH_SEMI,
              CH_QUOTE: begin
                // An unquoted value ends here and the character is seen again.
                close_value();
                again = 1'b1;
              end
              default: store_byte(c);
            endcase
          end
        end
        PH_SEP_PRE: begin
          if (term) begin
            finish_string();
          end else if (take_space(c)) begin
          end else if (c == CH_COMMA || c == CH_SEMI) begin
            ph      = PH_SEP_POST;
            nl_used = 1'b0;
          end else begin
            raise_error(1'b0);
          end
        end
        PH_SEP_POST: begin
          if (term) begin
            finish_string();
          end else if (take_space(c)) begin
          end else begin
            ph    = PH_FIRST;
            again = 1'b1;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = CAPACITY_RESET;
      start_string();
      dn_results_due.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (push_i && !full_i) parse_char(item_i);
      if (pop_i && !empty_i) begin
        if (dn_results_due.size() == 0) begin
          fails++;
          $display("%0t: expected no result, got kind %0d attr %0d byte %02h len %0d",
                   $time, res_i.kind, res_i.attr_code, res_i.data_byte,
                   res_i.value_length);
        end else begin
          want = dn_results_due.pop_front();
          if (res_i.kind !== want.kind || res_i.attr_code !== want.attr_code ||
              res_i.data_byte !== want.data_byte ||
              res_i.value_length !== want.value_length) begin
            fails++;
            $display("%0t: expected kind %0d attr %0d byte %02h len %0d, got %0d %0d %02h %0d",
                     $time, want.kind, want.attr_code, want.data_byte,
                     want.value_length, res_i.kind, res_i.attr_code,
                     res_i.data_byte, res_i.value_length);
          end
        end
      end
    end
    fail_count_o <= fails;
    due_count_o  <= dn_results_due.size();
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for dn_string_parser
// Feeds distinguished-name strings one character per transaction: a few
// hand-picked strings first, then random strings that are mostly well formed
// with occasional broken keys, spacing, values and separators, under several
// buffer capacities. The checker predicts and compares; this module drives
// the stimulus, paces the result side and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import dnp_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    PACE_EAGER,
    PACE_COIN,
    PACE_SPARSE,
    PACE_PERIODIC
  } pop_pace_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  dnp_in_t     dn_in     = '0;
  logic        empty;
  logic        pop       = 1'b0;
  dnp_out_t    dn_out;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned quiet_cycles = 0;
  pop_pace_e   pace         = PACE_EAGER;
  int unsigned pace_left    = 0;
  int unsigned burst_left   = 1;
  int unsigned sent         = 0;
  logic        push_on      = 1'b0;
  logic [7:0]  dn_chars[$];

  string known_keys[7] = '{"CN", "L", "ST", "O", "OU", "C", "STREET"};
  string odd_keys[8]   = '{"cn", "Ou", "STREETS", "S T", "C N", "OU1", "ST REET", "x"};

  dn_string_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (dn_in),
    .empty      (empty),
    .pop        (pop),
    .out_o      (dn_out),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  dn_parse_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .item_i      (dn_in),
    .empty_i     (empty),
    .pop_i       (pop),
    .res_i       (dn_out),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The result side changes its pace every so often.
  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      pace      <= pop_pace_e'($urandom_range(0, 3));
      pace_left <= $urandom_range(8, 150);
    end else begin
      pace_left <= pace_left - 1;
    end
    case (pace)
      PACE_EAGER:  pop <= 1'b1;
      PACE_COIN:   pop <= 1'($urandom_range(0, 1));
      PACE_SPARSE: pop <= ($urandom_range(0, 7) == 0);
      default:     pop <= (pace_left[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_char(input logic func, input logic [7:0] ch);
    push    <= 1'b1;
    push_on  = 1'b1;
    dn_in   <= {func, ch};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      push    <= 1'b0;
      push_on  = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic stop_sender();
    if (push_on) begin
      push    <= 1'b0;
      push_on  = 1'b0;
    end
  endtask

  task automatic wait_drained();
    stop_sender();
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [15:0] value);
    wait_drained();
    // A string that ended in silence may still be inside the parser.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) dn_chars.push_back(s[i]);
  endtask

  task automatic send_dn(input logic use_nul);
    foreach (dn_chars[i]) send_char(1'b0, dn_chars[i]);
    if (use_nul) send_char(1'b0, CH_NUL);
    else send_char(1'b1, 8'($urandom));
    dn_chars.delete();
  endtask

  task automatic add_gap();
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (pick >= 12 && pick < 22) begin
      repeat ($urandom_range(1, 3)) dn_chars.push_back(CH_SPACE);
    end else if (pick >= 22 && pick < 31) begin
      dn_chars.push_back(CH_NL);
      repeat ($urandom_range(0, 2)) dn_chars.push_back(CH_SPACE);
    end else if (pick == 31) begin
      // A newline after a space is no longer skipped.
      dn_chars.push_back(CH_SPACE);
      dn_chars.push_back(CH_NL);
    end
  endtask

  task automatic add_key();
    int unsigned pick;
    logic [7:0]  ch;
    pick = $urandom_range(0, 15);
    if (pick < 12) begin
      add_text(known_keys[$urandom_range(0, 6)]);
    end else if (pick < 14) begin
      add_text(odd_keys[$urandom_range(0, 7)]);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 2))
          0:       ch = 8'($urandom_range(8'h30, 8'h39));
          1:       ch = 8'($urandom_range(8'h41, 8'h5A));
          default: ch = 8'($urandom_range(8'h61, 8'h7A));
        endcase
        dn_chars.push_back(ch);
      end
    end
  endtask

  task automatic add_value();
    int unsigned pick;
    logic [7:0]  ch;
    logic        plain;
    pick = $urandom_range(0, 11);
    if (pick == 1) begin
      dn_chars.push_back(CH_HASH);
      add_text("04");
    end else if (pick >= 2 && pick <= 4) begin
      dn_chars.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
        ch = 8'($urandom_range(1, 255));
        if (ch == CH_QUOTE || ch == CH_BSLASH) dn_chars.push_back(CH_BSLASH);
        dn_chars.push_back(ch);
      end
      if ($urandom_range(0, 15) != 0) dn_chars.push_back(CH_QUOTE);
    end else if (pick > 4) begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 7) == 0) begin
          dn_chars.push_back(CH_BSLASH);
          dn_chars.push_back(8'($urandom_range(1, 255)));
        end else begin
          plain = 1'b0;
          while (!plain) begin
            ch = 8'($urandom_range(1, 255));
            case (ch)
              CH_COMMA, CH_EQ, CH_NL, CH_PLUS, CH_LT, CH_GT, CH_HASH, CH_SEMI,
              CH_BSLASH, CH_QUOTE: plain = 1'b0;
              default:             plain = 1'b1;
            endcase
          end
          dn_chars.push_back(ch);
        end
      end
      if ($urandom_range(0, 5) == 0) dn_chars.push_back(CH_SPACE);
    end
  endtask

  task automatic build_dn();
    int unsigned parts;
    int unsigned tail;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) dn_chars.push_back(8'($urandom_range(1, 255)));
      return;
    end
    parts = $urandom_range(1, 4);
    for (int p = 0; p < parts; p++) begin
      if (p > 0) begin
        add_gap();
        dn_chars.push_back($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
        add_gap();
      end
      add_key();
      add_gap();
      if ($urandom_range(0, 30) != 0) dn_chars.push_back(CH_EQ);
      add_gap();
      add_value();
    end
    tail = $urandom_range(0, 15);
    if (tail == 0) begin
      add_gap();
      add_text("x");
    end else if (tail == 1) begin
      dn_chars.push_back(CH_SEMI);
      add_gap();
    end else if (tail < 5) begin
      add_gap();
    end
  endtask

  task automatic run_phase(input logic [15:0] cap_value, input int unsigned items);
    int unsigned target;
    set_capacity(cap_value);
    target = sent + items;
    while (sent < target) begin
      build_dn();
      send_dn($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-picked strings at the reset capacity.
    add_text("CN=");
    dn_chars.push_back(8'hFF);
    send_dn(1'b0);
    add_text(" ");
    send_dn(1'b1);
    add_text("O=#");
    send_dn(1'b0);
    add_text("L=");
    dn_chars.push_back(CH_QUOTE);
    send_dn(1'b0);
    add_text("C=");
    dn_chars.push_back(CH_BSLASH);
    send_dn(1'b0);
    add_text("ST=,");
    send_dn(1'b0);

    run_phase(16'd0, 60);
    run_phase(16'd1, 80);
    run_phase(16'd12, 180);
    run_phase(16'($urandom_range(20, 200)), 180);
    run_phase(CAPACITY_RESET, 180);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: dn_string_parser.f
sv/dnp_pkg.sv
sv/dnp_front.sv
sv/dnp_back.sv
sv/dnp_rfifo.sv
sv/dn_string_parser.sv
tb/sv/dn_parse_check.sv
tb/sv/tb.sv
